// ===== rtl/core/pp_pkg.sv =====
// Package for the perspective projection block.
// Holds payload structs, register indexes, fixed-point constants and a magnitude helper.
// No dependencies.
package pp_pkg;

  localparam int CoordWidth = 48;
  localparam int FracBits   = 16;
  localparam int QuoW       = CoordWidth + FracBits;
  localparam int HalfW      = 32;
  localparam int ProdW      = QuoW + HalfW;
  localparam int ScreenW    = 16;
  localparam int CenterW    = 13;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int LimW       = 41;
  localparam int RW         = 43;

  localparam logic [CoordWidth-1:0] FixOneIn = CoordWidth'(1) << FracBits;
  localparam logic [QuoW-1:0]       FixOne   = QuoW'(1) << FracBits;
  localparam logic [QuoW-1:0]       FarDepth = QuoW'(1000000) << FracBits;
  localparam logic [QuoW-1:0]       ClampLim = QuoW'(1) << (LimW - 1);
  localparam logic [CfgDataW-1:0]   CfgOne   = CfgDataW'(1) << FracBits;
  localparam logic signed [RW-1:0]  RMax     = RW'(32767);
  localparam logic signed [RW-1:0]  RMin     = -RW'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    CfgViewDist = 3'd0,
    CfgScaleX   = 3'd1,
    CfgScaleY   = 3'd2,
    CfgCenterX  = 3'd3,
    CfgCenterY  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                         req_type;
    logic signed [CoordWidth-1:0] coord_x;
    logic signed [CoordWidth-1:0] coord_y;
    logic signed [CoordWidth-1:0] coord_z;
    logic signed [CoordWidth-1:0] coord_w;
  } pp_in_t;

  typedef struct packed {
    logic signed [ScreenW-1:0] screen_x;
    logic signed [ScreenW-1:0] screen_y;
    logic                      clamped;
  } pp_out_t;

  typedef struct packed {
    logic [ScreenW-1:0] val;
    logic               clip;
  } pp_coord_t;

  function automatic logic [CoordWidth-1:0] pp_mag(input logic [CoordWidth-1:0] v);
    return v[CoordWidth-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/core/pp_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per item.
// Depends on nothing but its parameters.
module pp_div_cell #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 48,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;
  logic               valid_q;
  logic [DEN_W-1:0]   rem_d, rem_q;
  logic [NUM_W-1:0]   num_d, num_q;
  logic [DEN_W-1:0]   den_q;
  logic [SIDE_W-1:0]  side_q;

  always_comb begin
    trial = {rem_i, num_i[NUM_W-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_d = {num_i[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/core/pp_div_row.sv =====
// Row of division cells, one quotient bit per cell; every cell is registered and held by en_i.
// Depends on pp_div_cell.
module pp_div_row #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 48,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_w [NUM_W+1];
  logic [DEN_W-1:0]  rem_w   [NUM_W+1];
  logic [NUM_W-1:0]  num_w   [NUM_W+1];
  logic [DEN_W-1:0]  den_w   [NUM_W+1];
  logic [SIDE_W-1:0] side_w  [NUM_W+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = rem_i;
  assign num_w[0]   = num_i;
  assign den_w[0]   = den_i;
  assign side_w[0]  = side_i;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    pp_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(valid_w[i]),
      .rem_i  (rem_w[i]),
      .num_i  (num_w[i]),
      .den_i  (den_w[i]),
      .side_i (side_w[i]),
      .valid_o(valid_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .num_o  (num_w[i+1]),
      .den_o  (den_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  assign valid_o = valid_w[NUM_W] & (rem_w[NUM_W] == rem_w[NUM_W] ) &
                   (den_w[NUM_W] == den_w[NUM_W]);
  assign quo_o   = num_w[NUM_W];
  assign side_o  = side_w[NUM_W];

endmodule

// ===== rtl/core/pp_wide_mul.sv =====
// Two-stage 64 x 32 multiplier built from two 32 x 32 partial products.
// Depends on pp_pkg.
module pp_wide_mul import pp_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [QuoW-1:0]   a_i,
  input  logic [HalfW-1:0]  b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ProdW-1:0]  prod_o,
  output logic [SIDE_W-1:0] side_o
);

  logic                  v1_q, v2_q;
  logic [2*HalfW-1:0]    pl_q, ph_q;
  logic [ProdW-1:0]      prod_q;
  logic [SIDE_W-1:0]     s1_q, s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= a_i[HalfW-1:0] * b_i;
      ph_q   <= a_i[QuoW-1:HalfW] * b_i;
      s1_q   <= side_i;
      prod_q <= {{HalfW{1'b0}}, pl_q} + {ph_q, {HalfW{1'b0}}};
      s2_q   <= s1_q;
    end
  end

  assign valid_o = v2_q;
  assign prod_o  = prod_q;
  assign side_o  = s2_q;

endmodule

// ===== rtl/core/perspective_projection.sv =====
// Perspective projection of one point per transfer to saturated screen coordinates.
// Stages in order: 64-cell divide row, multiply, overflow-check register, 64-cell divide
// row, multiply, output register. Throughput one point per cycle; the whole
// chain advances together and holds while a result waits on a stalled output.
// Reset is asynchronous: clears all valid flags, distance and scales to 1.0, centres to 0.
// Depends on pp_pkg, pp_div_row and pp_wide_mul.
module perspective_projection import pp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pp_in_t              in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pp_out_t             out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] view_dist_q, scale_x_q, scale_y_q;
  logic [CenterW-1:0]  center_x_q, center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_dist_q <= CfgOne;
      scale_x_q   <= CfgOne;
      scale_y_q   <= CfgOne;
      center_x_q  <= '0;
      center_y_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgViewDist: view_dist_q <= cfg_data_i;
        CfgScaleX:   scale_x_q   <= cfg_data_i;
        CfgScaleY:   scale_y_q   <= cfg_data_i;
        CfgCenterX:  center_x_q  <= cfg_data_i[CenterW-1:0];
        CfgCenterY:  center_y_q  <= cfg_data_i[CenterW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic adv;
  logic out_valid_q;
  pp_out_t out_q;

  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~adv;

  // input split and first divide (by w, or by 1.0 as a bypass)
  logic [CoordWidth-1:0] xm, ym, zm, wm, den_a;
  logic hdiv, wzero, xs, ys, zs;

  always_comb begin
    xm    = pp_mag(in_data_i.coord_x);
    ym    = pp_mag(in_data_i.coord_y);
    zm    = pp_mag(in_data_i.coord_z);
    wm    = pp_mag(in_data_i.coord_w);
    hdiv  = in_data_i.req_type & (|wm);
    wzero = in_data_i.req_type & ~(|wm);
    den_a = hdiv ? wm : FixOneIn;
    xs    = in_data_i.coord_x[CoordWidth-1] ^ (hdiv & in_data_i.coord_w[CoordWidth-1]);
    ys    = in_data_i.coord_y[CoordWidth-1] ^ (hdiv & in_data_i.coord_w[CoordWidth-1]);
    zs    = in_data_i.coord_z[CoordWidth-1] ^ (hdiv & in_data_i.coord_w[CoordWidth-1]);
  end

  logic            va_x, va_y, va_z;
  logic [QuoW-1:0] qa_x, qa_y, qa_z;
  logic            sa_x, sa_y;
  logic [1:0]      sa_z;

  pp_div_row #(.NUM_W(QuoW), .DEN_W(CoordWidth), .SIDE_W(1)) u_div_ax (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(in_valid_i),
    .rem_i('0), .num_i({xm, {FracBits{1'b0}}}), .den_i(den_a), .side_i(xs),
    .valid_o(va_x), .quo_o(qa_x), .side_o(sa_x)
  );

  pp_div_row #(.NUM_W(QuoW), .DEN_W(CoordWidth), .SIDE_W(1)) u_div_ay (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(in_valid_i),
    .rem_i('0), .num_i({ym, {FracBits{1'b0}}}), .den_i(den_a), .side_i(ys),
    .valid_o(va_y), .quo_o(qa_y), .side_o(sa_y)
  );

  pp_div_row #(.NUM_W(QuoW), .DEN_W(CoordWidth), .SIDE_W(2)) u_div_az (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(in_valid_i),
    .rem_i('0), .num_i({zm, {FracBits{1'b0}}}), .den_i(den_a), .side_i({zs, wzero}),
    .valid_o(va_z), .quo_o(qa_z), .side_o(sa_z)
  );

  // depth fix-up for zero w and zero z
  logic [QuoW-1:0] zd;
  logic            z_zero, zs_f, negx, negy, va;

  always_comb begin
    z_zero = ~(|qa_z);
    zd     = sa_z[0] ? FarDepth : (z_zero ? FixOne : qa_z);
    zs_f   = sa_z[1] & ~sa_z[0] & ~z_zero;
    negx   = sa_x ^ zs_f;
    negy   = ~sa_y ^ zs_f;
    va     = va_x & va_y & va_z;
  end

  logic             vm_x, vm_y;
  logic [ProdW-1:0] pm_x, pm_y;
  logic [QuoW:0]    sm_x;
  logic             sm_y;

  pp_wide_mul #(.SIDE_W(QuoW + 1)) u_mul_dx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(va),
    .a_i(qa_x), .b_i(view_dist_q), .side_i({negx, zd}),
    .valid_o(vm_x), .prod_o(pm_x), .side_o(sm_x)
  );

  pp_wide_mul #(.SIDE_W(1)) u_mul_dy (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(va),
    .a_i(qa_y), .b_i(view_dist_q), .side_i(negy),
    .valid_o(vm_y), .prod_o(pm_y), .side_o(sm_y)
  );

  // overflow check ahead of the second divide
  logic            s_valid_q;
  logic            s_satx_q, s_saty_q, s_negx_q, s_negy_q;
  logic [QuoW-1:0] s_remx_q, s_remy_q, s_lox_q, s_loy_q, s_den_q;
  logic            satx, saty;

  always_comb begin
    satx = QuoW'(pm_x[ProdW-1:QuoW]) >= sm_x[QuoW-1:0];
    saty = QuoW'(pm_y[ProdW-1:QuoW]) >= sm_x[QuoW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (adv) begin
      s_valid_q <= vm_x & vm_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_satx_q <= satx;
      s_saty_q <= saty;
      s_remx_q <= satx ? '0 : QuoW'(pm_x[ProdW-1:QuoW]);
      s_remy_q <= saty ? '0 : QuoW'(pm_y[ProdW-1:QuoW]);
      s_lox_q  <= pm_x[QuoW-1:0];
      s_loy_q  <= pm_y[QuoW-1:0];
      s_den_q  <= sm_x[QuoW-1:0];
      s_negx_q <= sm_x[QuoW];
      s_negy_q <= sm_y;
    end
  end

  logic            vb_x, vb_y;
  logic [QuoW-1:0] qb_x, qb_y;
  logic [1:0]      sb_x, sb_y;

  pp_div_row #(.NUM_W(QuoW), .DEN_W(QuoW), .SIDE_W(2)) u_div_bx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(s_valid_q),
    .rem_i(s_remx_q), .num_i(s_lox_q), .den_i(s_den_q), .side_i({s_satx_q, s_negx_q}),
    .valid_o(vb_x), .quo_o(qb_x), .side_o(sb_x)
  );

  pp_div_row #(.NUM_W(QuoW), .DEN_W(QuoW), .SIDE_W(2)) u_div_by (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(s_valid_q),
    .rem_i(s_remy_q), .num_i(s_loy_q), .den_i(s_den_q), .side_i({s_saty_q, s_negy_q}),
    .valid_o(vb_y), .quo_o(qb_y), .side_o(sb_y)
  );

  logic             vc_x, vc_y, sc_x, sc_y;
  logic [ProdW-1:0] pc_x, pc_y;

  pp_wide_mul #(.SIDE_W(1)) u_mul_sx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(vb_x & vb_y),
    .a_i(sb_x[1] ? '1 : qb_x), .b_i(scale_x_q), .side_i(sb_x[0]),
    .valid_o(vc_x), .prod_o(pc_x), .side_o(sc_x)
  );

  pp_wide_mul #(.SIDE_W(1)) u_mul_sy (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv), .valid_i(vb_x & vb_y),
    .a_i(sb_y[1] ? '1 : qb_y), .b_i(scale_y_q), .side_i(sb_y[0]),
    .valid_o(vc_y), .prod_o(pc_y), .side_o(sc_y)
  );

  function automatic pp_coord_t screen_fn(input logic [ProdW-1:0] m, input logic neg,
                                          input logic [CenterW-1:0] ctr);
    logic [QuoW-1:0]       mi_full;
    logic [LimW-1:0]       mi;
    logic                  frac;
    logic signed [RW-1:0]  r;
    pp_coord_t             res;
    mi_full  = m[ProdW-1:2*FracBits];
    frac     = |m[2*FracBits-1:0];
    mi       = (mi_full > ClampLim) ? ClampLim[LimW-1:0] : mi_full[LimW-1:0];
    if (!neg) begin
      r = $signed(RW'(mi)) + $signed(RW'(ctr));
    end else begin
      r = $signed(RW'(ctr)) - $signed(RW'(mi)) -
          $signed(RW'(frac && (mi < LimW'(ctr))));
    end
    res.clip = 1'b0;
    if (r > RMax) begin
      r        = RMax;
      res.clip = 1'b1;
    end else if (r < RMin) begin
      r        = RMin;
      res.clip = 1'b1;
    end
    res.val = r[ScreenW-1:0];
    return res;
  endfunction

  pp_coord_t fx, fy;

  always_comb begin
    fx = screen_fn(pc_x, sc_x, center_x_q);
    fy = screen_fn(pc_y, sc_y, center_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vc_x & vc_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.screen_x <= fx.val;
      out_q.screen_y <= fy.val;
      out_q.clamped  <= fx.clip | fy.clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_rows_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_x == va_z) && (va_y == va_z) && (vb_x == vb_y) && (vc_x == vc_y))
    else $error("parallel lanes out of step");

  a_clamp_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clamped) |->
      (out_data_o.screen_x == 16'sh7fff || out_data_o.screen_x == -16'sh8000 ||
       out_data_o.screen_y == 16'sh7fff || out_data_o.screen_y == -16'sh8000))
    else $error("clamped flag without a saturated coordinate");

endmodule
